// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the round-robin timing block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RRWT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define RRWT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- design/rrwt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin timing package
// Field widths, register codes, control structs and saturation helpers.
// ----------------------------------------------------------------------------
package rrwt_pkg;

    localparam int BURST_IN_W  = 16;
    localparam int QUANTUM_W   = 16;
    localparam int INDEX_OUT_W = 4;
    localparam int TIME_OUT_W  = 20;
    localparam int SUM_OUT_W   = 24;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1);
    localparam logic [63:0] TIME_OUT_MAX = (64'd1 << TIME_OUT_W) - 64'd1;
    localparam logic [63:0] SUM_OUT_MAX  = (64'd1 << SUM_OUT_W) - 64'd1;

    // Register index decoded from the word address.
    localparam logic REG_TIME_QUANTUM = 1'b0;

    typedef struct packed {
        logic load;
        logic run_step;
        logic idx_clear;
        logic out_load;
        logic idx_inc;
        logic set_clear;
    } rrwt_cmd_t;

    typedef struct packed {
        logic pending_empty;
        logic idx_last;
    } rrwt_status_t;

    function automatic logic [TIME_OUT_W-1:0] sat_time(input logic [63:0] v);
        return (v > TIME_OUT_MAX) ? TIME_OUT_MAX[TIME_OUT_W-1:0] : v[TIME_OUT_W-1:0];
    endfunction

    function automatic logic [SUM_OUT_W-1:0] sat_sum(input logic [63:0] v);
        return (v > SUM_OUT_MAX) ? SUM_OUT_MAX[SUM_OUT_W-1:0] : v[SUM_OUT_W-1:0];
    endfunction

endpackage

// ----- design/rrwt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst request channel
// Carries one burst time and the end-of-set flag per request.
// ----------------------------------------------------------------------------
interface rrwt_in_if
    import rrwt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BURST_IN_W-1:0] burst_time;
    logic                  last_process;

    modport source (output valid, burst_time, last_process, input ready);
    modport sink (input valid, burst_time, last_process, output ready);
endinterface

// ----- design/rrwt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries the timing of one process per request, with totals on the last.
// ----------------------------------------------------------------------------
interface rrwt_out_if
    import rrwt_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [INDEX_OUT_W-1:0] process_index;
    logic [TIME_OUT_W-1:0]  waiting_time;
    logic [TIME_OUT_W-1:0]  turnaround_time;
    logic [SUM_OUT_W-1:0]   total_waiting;
    logic [SUM_OUT_W-1:0]   total_turnaround;
    logic                   overflow;
    logic                   last_result;

    modport source (
        output valid, process_index, waiting_time, turnaround_time,
               total_waiting, total_turnaround, overflow, last_result,
        input  ready
    );
    modport sink (
        input  valid, process_index, waiting_time, turnaround_time,
               total_waiting, total_turnaround, overflow, last_result,
        output ready
    );
endinterface

// ----- design/rrwt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/rrwt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin timing controller
// Sequences loading, the round-robin service pass and result delivery.
// ----------------------------------------------------------------------------
module rrwt_ctrl
    import rrwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_last,
    output logic         in_ready,
    input  logic         out_ready,
    output logic         out_valid,
    input  rrwt_status_t status,
    output rrwt_cmd_t    cmd
);
    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN_RD,
        S_RUN_WR,
        S_OUT_RD,
        S_OUT_CALC,
        S_OUT_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_RUN_RD;
                    end
                end
            end
            S_RUN_RD:
            begin
                if (status.pending_empty)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_OUT_RD;
                end
                else
                begin
                    state_next = S_RUN_WR;
                end
            end
            S_RUN_WR:
            begin
                cmd.run_step = 1'b1;
                state_next   = S_RUN_RD;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_CALC;
            end
            S_OUT_CALC:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    if (status.idx_last)
                    begin
                        cmd.set_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_LOAD);
            out_valid_reg <= (state_next == S_OUT_HOLD);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
endmodule

// ----- design/rrwt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin timing datapath
// Process store, service clock, pending count, totals and result register.
// ----------------------------------------------------------------------------
module rrwt_dp
    import rrwt_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_WIDTH    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrwt_cmd_t              cmd,
    output rrwt_status_t           status,
    input  logic [BURST_IN_W-1:0]  burst_time,
    input  logic [QUANTUM_W-1:0]   time_quantum,
    output logic [INDEX_OUT_W-1:0] process_index,
    output logic [TIME_OUT_W-1:0]  waiting_time,
    output logic [TIME_OUT_W-1:0]  turnaround_time,
    output logic [SUM_OUT_W-1:0]   total_waiting,
    output logic [SUM_OUT_W-1:0]   total_turnaround,
    output logic                   overflow,
    output logic                   last_result
);
    localparam int BURST_W = (TIME_WIDTH < BURST_IN_W) ? TIME_WIDTH : BURST_IN_W;
    localparam int IDX_W   = $clog2(MAX_PROCESSES);
    localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
    localparam int NOW_W   = BURST_W + $clog2(MAX_PROCESSES);
    localparam int SUM_W   = NOW_W + $clog2(MAX_PROCESSES);
    localparam int ENTRY_W = 2 * BURST_W + NOW_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NOW_W-1:0] now_reg, now_next;
    logic             ovf_reg, ovf_next;
    logic [SUM_W-1:0] totw_reg, totw_next;
    logic [SUM_W-1:0] tott_reg, tott_next;

    logic [INDEX_OUT_W-1:0] res_index_reg;
    logic [TIME_OUT_W-1:0]  res_wait_reg;
    logic [TIME_OUT_W-1:0]  res_turn_reg;
    logic [SUM_OUT_W-1:0]   res_totw_reg;
    logic [SUM_OUT_W-1:0]   res_tott_reg;
    logic                   res_ovf_reg;
    logic                   res_last_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [BURST_W-1:0]   in_burst;
    logic [BURST_W-1:0]   rd_burst;
    logic [BURST_W-1:0]   rd_rem;
    logic [NOW_W-1:0]     rd_fin;
    logic [QUANTUM_W-1:0] q_eff;
    logic [BURST_W-1:0]   run_len;
    logic [BURST_W-1:0]   rem_left;
    logic [NOW_W-1:0]     now_sum;
    logic [NOW_W-1:0]     wait_val;
    logic [CNT_W-1:0]     idx_plus;
    logic                 idx_last;
    logic                 store_ok;
    logic                 rem_busy;

    rrwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Each entry holds the burst, the remaining service and the finish time.
    assign in_burst = burst_time[BURST_W-1:0];
    assign rd_burst = ram_rdata[ENTRY_W-1 -: BURST_W];
    assign rd_rem   = ram_rdata[NOW_W +: BURST_W];
    assign rd_fin   = ram_rdata[NOW_W-1:0];

    assign q_eff    = (time_quantum == '0) ? QUANTUM_W'(1) : time_quantum;
    assign run_len  = (QUANTUM_W'(rd_rem) < q_eff) ? rd_rem : q_eff[BURST_W-1:0];
    assign rem_left = rd_rem - run_len;
    assign now_sum  = now_reg + NOW_W'(run_len);
    assign rem_busy = (rd_rem != '0);
    assign wait_val = (rd_fin >= NOW_W'(rd_burst)) ? rd_fin - NOW_W'(rd_burst) : '0;

    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_last = (idx_plus == cnt_reg);
    assign store_ok = (cnt_reg < CNT_W'(MAX_PROCESSES));

    assign ram_we    = (cmd.load && store_ok) || (cmd.run_step && rem_busy);
    assign ram_waddr = cmd.load ? cnt_reg[IDX_W-1:0] : idx_reg;
    assign ram_wdata = cmd.load ? {in_burst, in_burst, NOW_W'(0)}
                                : {rd_burst, rem_left,
                                   (rem_left == '0) ? now_sum : rd_fin};

    always_comb
    begin
        cnt_next     = cnt_reg;
        pending_next = pending_reg;
        idx_next     = idx_reg;
        now_next     = now_reg;
        ovf_next     = ovf_reg;
        totw_next    = totw_reg;
        tott_next    = tott_reg;
        if (cmd.load)
        begin
            if (store_ok)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (in_burst != '0)
                begin
                    pending_next = pending_reg + CNT_W'(1);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.run_step)
        begin
            if (rem_busy)
            begin
                now_next = now_sum;
                if (rem_left == '0)
                begin
                    pending_next = pending_reg - CNT_W'(1);
                end
            end
            idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        if (cmd.out_load)
        begin
            totw_next = totw_reg + SUM_W'(wait_val);
            tott_next = tott_reg + SUM_W'(rd_fin);
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.set_clear)
        begin
            cnt_next     = '0;
            pending_next = '0;
            idx_next     = '0;
            now_next     = '0;
            ovf_next     = 1'b0;
            totw_next    = '0;
            tott_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pending_reg <= '0;
            idx_reg     <= '0;
            now_reg     <= '0;
            ovf_reg     <= 1'b0;
            totw_reg    <= '0;
            tott_reg    <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            pending_reg <= pending_next;
            idx_reg     <= idx_next;
            now_reg     <= now_next;
            ovf_reg     <= ovf_next;
            totw_reg    <= totw_next;
            tott_reg    <= tott_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_index_reg <= INDEX_OUT_W'(idx_reg);
            res_wait_reg  <= sat_time(64'(wait_val));
            res_turn_reg  <= sat_time(64'(rd_fin));
            res_totw_reg  <= idx_last ? sat_sum(64'(totw_next)) : '0;
            res_tott_reg  <= idx_last ? sat_sum(64'(tott_next)) : '0;
            res_ovf_reg   <= ovf_reg;
            res_last_reg  <= idx_last;
        end
    end

    assign status.pending_empty = (pending_reg == '0);
    assign status.idx_last      = idx_last;

    assign process_index    = res_index_reg;
    assign waiting_time     = res_wait_reg;
    assign turnaround_time  = res_turn_reg;
    assign total_waiting    = res_totw_reg;
    assign total_turnaround = res_tott_reg;
    assign overflow         = res_ovf_reg;
    assign last_result      = res_last_reg;
endmodule

// ----- design/round_robin_waiting_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin waiting time
// Loads burst times, runs round-robin service and reports per-process times.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Contents
//  burst     in   valid/ready                burst_time, last_process
//  result    out  valid/ready                per-process times, set totals
//  APB       in   psel/penable/pwrite/pready time_quantum at address 0
//
//  Loading accepts each valid burst request in the load state; the request flagged last
//  starts the pass. The pass visits every stored entry in index order (store read, then
//  update), round after round until all remaining service is zero. Each result then
//  passes store read, calculate and hold states and waits in hold for result ready.
//  Reset clears the counters only; the process store needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_waiting_time
    import rrwt_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_WIDTH    = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rrwt_in_if.sink               burst,
    rrwt_out_if.source            result
);
    logic [QUANTUM_W-1:0] tq_reg;
    logic [QUANTUM_W-1:0] tq_next;
    logic                 reg_sel;
    rrwt_cmd_t            cmd;
    rrwt_status_t         status;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        tq_next = tq_reg;
        prdata  = '0;
        case (reg_sel)
            REG_TIME_QUANTUM:
            begin
                prdata = APB_DATA_W'(tq_reg);
                if (psel && penable && pwrite)
                begin
                    tq_next = pwdata[QUANTUM_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_reg <= QUANTUM_RESET;
        end
        else
        begin
            tq_reg <= tq_next;
        end
    end

    rrwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (burst.valid),
        .in_last   (burst.last_process),
        .in_ready  (burst.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    rrwt_dp #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .burst_time       (burst.burst_time),
        .time_quantum     (tq_reg),
        .process_index    (result.process_index),
        .waiting_time     (result.waiting_time),
        .turnaround_time  (result.turnaround_time),
        .total_waiting    (result.total_waiting),
        .total_turnaround (result.total_turnaround),
        .overflow         (result.overflow),
        .last_result      (result.last_result)
    );

    `RRWT_NEVER(a_load_and_result, clk, rst_n, burst.ready && result.valid, "Loading while a result is pending")
    `RRWT_ASSERT(a_totals_on_last, clk, rst_n, (result.valid && !result.last_result) |-> (result.total_waiting == '0 && result.total_turnaround == '0), "Totals shown before the final result")
    `RRWT_ASSERT(a_wait_le_turn, clk, rst_n, result.valid |-> (result.waiting_time <= result.turnaround_time), "Waiting time exceeds turnaround time")
    `RRWT_ASSERT(a_reload_after_set, clk, rst_n, (result.valid && result.ready && result.last_result) |=> burst.ready, "Block not ready after the final result")
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin waiting time testbench
// Loads sets of burst times through the request channel and predicts the
// round-robin finish, waiting and total times of every process. Each result
// is checked against the prediction while the quantum register, set sizes,
// store overruns and the idle mix on both channels are varied.
// ----------------------------------------------------------------------------
module tb_top;
    import rrwt_pkg::*;

    localparam int PROC_SLOTS = 16;
    localparam logic [APB_ADDR_W-1:0] QUANTUM_ADDR = APB_ADDR_W'(4 * REG_TIME_QUANTUM);

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] process_index;
        logic [TIME_OUT_W-1:0]  waiting_time;
        logic [TIME_OUT_W-1:0]  turnaround_time;
        logic [SUM_OUT_W-1:0]   total_waiting;
        logic [SUM_OUT_W-1:0]   total_turnaround;
        logic                   overflow;
        logic                   last_result;
    } rr_result_t;

    class rr_wait_checker;
        logic [QUANTUM_W-1:0]  quantum;
        logic [BURST_IN_W-1:0] stored [PROC_SLOTS];
        int unsigned           loaded;
        bit                    dropped;
        rr_result_t            expected_times [$];
        int unsigned           errors;
        int unsigned           reported;
        int unsigned           checked;
        int unsigned           sets;
        int unsigned           overrun_sets;

        function new();
            quantum = QUANTUM_RESET;
            loaded = 0;
            dropped = 0;
            errors = 0;
            reported = 0;
            checked = 0;
            sets = 0;
            overrun_sets = 0;
        endfunction

        function void set_quantum(logic [QUANTUM_W-1:0] value);
            quantum = value;
        endfunction

        function int unsigned pending();
            return expected_times.size();
        endfunction

        function logic [TIME_OUT_W-1:0] clip_time(longint unsigned v);
            return (v > TIME_OUT_MAX) ? {TIME_OUT_W{1'b1}} : v[TIME_OUT_W-1:0];
        endfunction

        function logic [SUM_OUT_W-1:0] clip_sum(longint unsigned v);
            return (v > SUM_OUT_MAX) ? {SUM_OUT_W{1'b1}} : v[SUM_OUT_W-1:0];
        endfunction

        function string describe(rr_result_t r);
            return $sformatf("idx=%0d wait=%0d turn=%0d totw=%0d tott=%0d ovf=%0b last=%0b",
                             r.process_index, r.waiting_time, r.turnaround_time,
                             r.total_waiting, r.total_turnaround, r.overflow,
                             r.last_result);
        endfunction

        // A request flagged last runs the whole round-robin pass over the set.
        function void note_burst(logic [BURST_IN_W-1:0] b, logic is_last);
            longint unsigned slice;
            longint unsigned now;
            longint unsigned run;
            longint unsigned wait_t;
            longint unsigned sum_wait;
            longint unsigned sum_turn;
            longint unsigned left [PROC_SLOTS];
            longint unsigned done_at [PROC_SLOTS];
            int unsigned     busy;
            rr_result_t      r;
            if (loaded < PROC_SLOTS)
            begin
                stored[loaded] = b;
                loaded++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!is_last)
            begin
                return;
            end
            slice = (quantum == '0) ? 1 : quantum;
            now = 0;
            busy = 0;
            sum_wait = 0;
            sum_turn = 0;
            for (int i = 0; i < loaded; i++)
            begin
                left[i] = stored[i];
                done_at[i] = 0;
                if (left[i] != 0)
                begin
                    busy++;
                end
            end
            while (busy != 0)
            begin
                for (int i = 0; i < loaded; i++)
                begin
                    if (left[i] != 0)
                    begin
                        run = (left[i] < slice) ? left[i] : slice;
                        now += run;
                        left[i] -= run;
                        if (left[i] == 0)
                        begin
                            done_at[i] = now;
                            busy--;
                        end
                    end
                end
            end
            for (int i = 0; i < loaded; i++)
            begin
                wait_t = (done_at[i] >= stored[i]) ? done_at[i] - stored[i] : 0;
                sum_wait += wait_t;
                sum_turn += done_at[i];
                r.process_index = INDEX_OUT_W'(i);
                r.waiting_time = clip_time(wait_t);
                r.turnaround_time = clip_time(done_at[i]);
                r.total_waiting = '0;
                r.total_turnaround = '0;
                r.overflow = dropped;
                r.last_result = (i + 1 == loaded);
                if (i + 1 == loaded)
                begin
                    r.total_waiting = clip_sum(sum_wait);
                    r.total_turnaround = clip_sum(sum_turn);
                end
                expected_times.push_back(r);
            end
            sets++;
            if (dropped)
            begin
                overrun_sets++;
            end
            loaded = 0;
            dropped = 1'b0;
        endfunction

        function void check_result(rr_result_t got);
            rr_result_t want;
            if (expected_times.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("Unexpected result with nothing pending: %s", describe(got));
                end
                return;
            end
            want = expected_times.pop_front();
            checked++;
            if (got.process_index !== want.process_index
                || got.waiting_time !== want.waiting_time
                || got.turnaround_time !== want.turnaround_time
                || got.total_waiting !== want.total_waiting
                || got.total_turnaround !== want.total_turnaround
                || got.overflow !== want.overflow
                || got.last_result !== want.last_result)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("Mismatch at %0t: expected %s", $realtime, describe(want));
                    $display("                 actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rrwt_in_if  burst_ch ();
    rrwt_out_if result_ch ();

    rr_wait_checker sb;
    int unsigned    send_idle_pct = 11;
    int unsigned    recv_idle_pct = 65;
    int unsigned    items_sent = 0;
    int unsigned    quantum_settings = 1;

    round_robin_waiting_time #(
        .MAX_PROCESSES(PROC_SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .burst(burst_ch),
        .result(result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready)
        begin
            sb.check_result(rr_result_t'{result_ch.process_index, result_ch.waiting_time,
                                         result_ch.turnaround_time, result_ch.total_waiting,
                                         result_ch.total_turnaround, result_ch.overflow,
                                         result_ch.last_result});
        end
    end

    task automatic drive_burst(input logic [BURST_IN_W-1:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            burst_ch.valid <= 1'b0;
            @(posedge clk);
        end
        burst_ch.valid <= 1'b1;
        burst_ch.burst_time <= b;
        burst_ch.last_process <= is_last;
        do
            @(posedge clk);
        while (!burst_ch.ready);
        items_sent++;
        sb.note_burst(b, is_last);
    endtask

    task automatic wait_drained();
        burst_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // The quantum only changes once the previous set has been fully reported.
    task automatic change_quantum(input logic [QUANTUM_W-1:0] value);
        wait_drained();
        repeat (8) @(posedge clk);
        apb_write(QUANTUM_ADDR, {16'($urandom_range(65535)), value});
        sb.set_quantum(value);
        quantum_settings++;
    endtask

    // Burst sizes are bounded by 160 rounds of the quantum (mostly by 24) and by 65535 to keep passes short.
    task automatic send_random_set();
        int unsigned count;
        int unsigned rounds;
        int unsigned slice;
        int unsigned hi;
        int unsigned pick;
        logic [BURST_IN_W-1:0] b;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            count = $urandom_range(PROC_SLOTS + 4, PROC_SLOTS + 1);
        end
        else if (pick < 22)
        begin
            count = $urandom_range(PROC_SLOTS, 9);
        end
        else
        begin
            count = $urandom_range(8, 1);
        end
        rounds = ($urandom_range(9) == 0) ? $urandom_range(160, 25) : $urandom_range(24, 1);
        slice = (sb.quantum == '0) ? 1 : sb.quantum;
        hi = slice * rounds;
        if (hi > 65535)
        begin
            hi = 65535;
        end
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: b = '0;
                1: b = BURST_IN_W'(hi);
                default: b = BURST_IN_W'($urandom_range(hi));
            endcase
            drive_burst(b, i == count - 1);
        end
    endtask

    task automatic random_phase(input int unsigned amount);
        int unsigned target;
        target = items_sent + amount;
        while (items_sent < target)
        begin
            send_random_set();
            if ($urandom_range(7) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        burst_ch.valid <= 1'b0;
        burst_ch.burst_time <= '0;
        burst_ch.last_process <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_burst(16'd0, 1'b1);
        drive_burst(16'd3, 1'b0);
        drive_burst(16'd0, 1'b0);
        drive_burst(16'd5, 1'b1);

        change_quantum(16'hFFFF);
        drive_burst(16'hFFFF, 1'b0);
        drive_burst(16'd0, 1'b0);
        drive_burst(16'hFFFF, 1'b0);
        drive_burst(16'd1, 1'b1);
        for (int i = 0; i < PROC_SLOTS; i++)
        begin
            drive_burst(BURST_IN_W'($urandom_range(65535)), 1'b0);
        end
        drive_burst(16'hFFFF, 1'b1);

        change_quantum(16'd1);
        random_phase(56);
        change_quantum(16'd0);
        random_phase(56);

        send_idle_pct = 65;
        recv_idle_pct = 11;
        change_quantum(16'd3);
        random_phase(56);
        change_quantum(QUANTUM_W'($urandom_range(65535, 2)));
        random_phase(56);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        change_quantum(QUANTUM_W'($urandom_range(65535, 2)));
        random_phase(56);
        change_quantum(16'hFFFF);
        random_phase(56);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
        end
        $display("Checked %0d results from %0d process sets, %0d of them overrunning the store,",
                 sb.checked, sb.sets, sb.overrun_sets);
        $display("with %0d quantum settings and three mixes of idle cycles on the channels.",
                 quantum_settings);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Run did not finish in time.");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- round_robin_waiting_time.f -----
+incdir+design
design/rrwt_pkg.sv
design/rrwt_in_if.sv
design/rrwt_out_if.sv
design/rrwt_ram.sv
design/rrwt_ctrl.sv
design/rrwt_dp.sv
design/round_robin_waiting_time.sv
tb/sv/tb_top.sv
